@@ rtl/git_index_stream_parser_defines.svh @@
// Assertion macros shared by the index stream parser RTL.
`ifndef GIT_INDEX_STREAM_PARSER_DEFINES_SVH
`define GIT_INDEX_STREAM_PARSER_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define GISP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define GISP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/gisp_pkg.sv @@
// Types and constants shared by the index stream parser modules.
`timescale 1ns / 1ps
`default_nettype none

package gisp_pkg;

	// Configuration port geometry and register indexes.
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 32;
	localparam logic [CFG_INDEX_W-1:0] CFG_VER_FLOOR = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_VER_CEIL  = 2'd1;
	localparam logic [31:0] VER_FLOOR_RESET = 32'd2;
	localparam logic [31:0] VER_CEIL_RESET  = 32'd2;

	// File format constants.
	localparam logic [31:0] SIGNATURE = 32'h4449_5243;
	localparam int OFF_W = 6;
	localparam logic [OFF_W-1:0] OFF_SIG_LAST   = 6'd3;
	localparam logic [OFF_W-1:0] OFF_VER_LAST   = 6'd7;
	localparam logic [OFF_W-1:0] OFF_COUNT_LAST = 6'd11;
	localparam logic [OFF_W-1:0] OFF_ENTRY_LAST = 6'd61;

	// Record kinds.
	localparam logic [4:0] K_COUNT     = 5'd0;
	localparam logic [4:0] K_STAT_BASE = 5'd1;
	localparam logic [4:0] K_FLAGS     = 5'd16;
	localparam logic [4:0] K_NAME      = 5'd17;
	localparam logic [4:0] K_END       = 5'd18;
	localparam logic [4:0] K_VERSION   = 5'd19;
	localparam logic [4:0] K_ERROR     = 5'd20;

	// Error codes.
	typedef enum logic [2:0] {
		ERR_NONE      = 3'd0,
		ERR_SIGNATURE = 3'd1,
		ERR_VERSION   = 3'd2,
		ERR_NUL       = 3'd3,
		ERR_TRUNCATED = 3'd4
	} err_t;

	// Parse phases.
	typedef enum logic [2:0] {
		PH_HEADER,
		PH_ENTRY,
		PH_NAME,
		PH_NUL,
		PH_PAD,
		PH_TRAILER,
		PH_HALT
	} phase_t;

	// One input transaction as held in the input register.
	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_file;
	} gisp_item_t;

	// One result record.
	typedef struct packed {
		logic [4:0]  record_kind;
		logic [31:0] record_value;
		logic [30:0] entry_number;
		err_t        error_code;
	} gisp_result_t;

	// Configuration values seen by the parse core.
	typedef struct packed {
		logic [31:0] ver_floor;
		logic [31:0] ver_ceil;
	} gisp_cfg_t;

endpackage

`default_nettype wire

@@ rtl/git_index_stream_parser.sv @@
// Top level of the index stream parser: byte input, record output, config port.
//
// The input channel (in_valid, in_stall, data_byte, end_of_file) carries one
// byte of an index file per transaction; end_of_file marks the last byte.
// The output channel (out_valid, out_stall, record_kind, record_value,
// entry_number, error_code) carries at most one record per input byte.
// The config port writes the lowest accepted version (index 0) or the highest
// (index 1) when cfg_write is high; the user must write it only while the parser
// is idle, which the block itself does not enforce. A byte accepted into the
// input register is decoded by the parse core, and its record is loaded into the
// result register. Throughput: one byte per cycle while out_stall does not hold a
// record; the parse core consumes a byte whenever the result register is free.
// Reset clears the parse state, empties both registers and loads 2 into both
// version bounds. While out_stall holds a record, the byte behind it waits
// in the input register and in_stall rises; nothing is dropped. After an
// error record the parser ignores every byte until reset.
`timescale 1ns / 1ps
`default_nettype none
`include "git_index_stream_parser_defines.svh"

module git_index_stream_parser #(
	parameter int ALIGN_BYTES      = 8,
	parameter int NAME_LENGTH_BITS = 12
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire logic [7:0]                       data_byte,
	input  wire logic                             end_of_file,
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output logic [4:0]                            record_kind,
	output logic [31:0]                           record_value,
	output logic [30:0]                           entry_number,
	output logic [2:0]                            error_code,
	input  wire logic                             cfg_write,
	input  wire logic [gisp_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [gisp_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import gisp_pkg::*;

	gisp_cfg_t    cfg;
	gisp_item_t   item_s1;
	gisp_result_t res;
	logic         item_valid_s1;
	logic         advance;
	logic         step;
	logic         res_valid;

	// The pipeline moves whenever the result register can take a new record.
	assign advance = !out_valid || !out_stall;
	assign step    = item_valid_s1 && advance;

	gisp_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	gisp_in_reg u_in (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.data_byte     (data_byte),
		.end_of_file   (end_of_file),
		.advance       (advance),
		.item_valid_s1 (item_valid_s1),
		.item_s1       (item_s1)
	);

	gisp_core #(
		.ALIGN_BYTES      (ALIGN_BYTES),
		.NAME_LENGTH_BITS (NAME_LENGTH_BITS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.item_s1   (item_s1),
		.cfg       (cfg),
		.res_valid (res_valid),
		.res       (res)
	);

	gisp_out_reg u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (advance),
		.step         (step),
		.res_valid    (res_valid),
		.res          (res),
		.out_valid    (out_valid),
		.record_kind  (record_kind),
		.record_value (record_value),
		.entry_number (entry_number),
		.error_code   (error_code)
	);

	// Error records and only error records carry a nonzero code.
	`GISP_ASSERT_NOW(a_err_code_match, out_valid, ((record_kind == K_ERROR) == (error_code != ERR_NONE)), "error code does not match record kind")

	// Header records belong to no entry.
	`GISP_ASSERT_NOW(a_header_entry_zero, out_valid && (record_kind == K_COUNT || record_kind == K_VERSION), entry_number == '0, "header record with nonzero entry number")

	// Input backpressure comes only from a held, stalled result.
	`GISP_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall, "input stalled without a stalled result")

	// Once an error record is delivered, no further record follows.
	`GISP_ASSERT_NEXT(a_halt_after_error, out_valid && !out_stall && record_kind == K_ERROR, !out_valid, "record delivered after an error")

endmodule

`default_nettype wire

@@ rtl/gisp_cfg_regs.sv @@
// Version bound configuration registers of the index stream parser.
`timescale 1ns / 1ps
`default_nettype none

module gisp_cfg_regs (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_write,
	input  wire logic [gisp_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [gisp_pkg::CFG_DATA_W-1:0]  cfg_data,
	output gisp_pkg::gisp_cfg_t                   cfg
);
	import gisp_pkg::*;

	logic [31:0] ver_floor_q;
	logic [31:0] ver_ceil_q;

	// Decode the register index; unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ver_floor_q <= VER_FLOOR_RESET;
			ver_ceil_q  <= VER_CEIL_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_VER_FLOOR: ver_floor_q <= cfg_data[31:0];
				CFG_VER_CEIL:  ver_ceil_q  <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	assign cfg.ver_floor = ver_floor_q;
	assign cfg.ver_ceil  = ver_ceil_q;

endmodule

`default_nettype wire

@@ rtl/gisp_in_reg.sv @@
// Input register stage of the index stream parser.
`timescale 1ns / 1ps
`default_nettype none

module gisp_in_reg (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [7:0]        data_byte,
	input  wire logic              end_of_file,
	input  wire logic              advance,
	output logic                   item_valid_s1,
	output gisp_pkg::gisp_item_t   item_s1
);
	import gisp_pkg::*;

	logic accept;

	// The held byte leaves only when the core steps; until then the input waits.
	assign in_stall = item_valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else begin
			item_valid_s1 <= accept || (item_valid_s1 && !advance);
		end
	end

	// Payload loads on each accepted transaction.
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.data_byte   <= data_byte;
			item_s1.end_of_file <= end_of_file;
		end
	end

endmodule

`default_nettype wire

@@ rtl/gisp_core.sv @@
// Parse state and per-byte decode of the index stream parser.
`timescale 1ns / 1ps
`default_nettype none

module gisp_core #(
	parameter int ALIGN_BYTES      = 8,
	parameter int NAME_LENGTH_BITS = 12
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 step,
	input  gisp_pkg::gisp_item_t      item_s1,
	input  gisp_pkg::gisp_cfg_t       cfg,
	output logic                      res_valid,
	output gisp_pkg::gisp_result_t    res
);
	import gisp_pkg::*;

	localparam int NLB = NAME_LENGTH_BITS;
	localparam int PW  = (ALIGN_BYTES > 2) ? $clog2(ALIGN_BYTES) : 1;
	localparam logic [PW-1:0] POS_LAST = PW'(ALIGN_BYTES - 1);

	phase_t          phase_q, phase_d;
	logic [OFF_W-1:0] off_q, off_d;
	logic [31:0]     acc_q, acc_d;
	logic [30:0]     remain_q, remain_d;
	logic [30:0]     entry_q, entry_d;
	logic [NLB-1:0]  len_q, len_d;
	logic [NLB-1:0]  seen_q, seen_d;
	logic [PW-1:0]   pos_q, pos_d;
	logic [PW-1:0]   pad_q, pad_d;

	logic [31:0]     acc_shift;
	logic [PW-1:0]   pos_inc;
	logic [PW-1:0]   pad_need;
	logic [15:0]     flags;
	logic            have;
	logic            finish;
	logic [4:0]      kind;
	logic [31:0]     value;
	logic [30:0]     number;
	err_t            err;

	assign acc_shift = {acc_q[23:0], item_s1.data_byte};
	assign pos_inc   = (pos_q == POS_LAST) ? '0 : pos_q + 1'b1;
	assign pad_need  = POS_LAST - pos_q;
	assign flags     = acc_shift[15:0];

	// Next state and result for the byte in the input register.
	always_comb begin
		phase_d  = phase_q;
		off_d    = off_q;
		acc_d    = acc_q;
		remain_d = remain_q;
		entry_d  = entry_q;
		len_d    = len_q;
		seen_d   = seen_q;
		pos_d    = pos_q;
		pad_d    = pad_q;
		have     = 1'b0;
		finish   = 1'b0;
		kind     = K_COUNT;
		value    = '0;
		number   = entry_q;
		err      = ERR_NONE;

		case (phase_q)
			PH_HEADER: begin
				acc_d = acc_shift;
				off_d = off_q + 1'b1;
				if (off_q == OFF_SIG_LAST) begin
					if (acc_shift != SIGNATURE) begin
						err = ERR_SIGNATURE;
					end
				end else if (off_q == OFF_VER_LAST) begin
					if (acc_shift < cfg.ver_floor || acc_shift > cfg.ver_ceil) begin
						err = ERR_VERSION;
					end else begin
						have   = 1'b1;
						kind   = K_VERSION;
						value  = acc_shift;
						number = '0;
					end
				end else if (off_q >= OFF_COUNT_LAST) begin
					have     = 1'b1;
					kind     = K_COUNT;
					value    = acc_shift;
					number   = '0;
					remain_d = acc_shift[31] ? '0 : acc_shift[30:0];
					phase_d  = (remain_d != '0) ? PH_ENTRY : PH_TRAILER;
					off_d    = '0;
					pos_d    = '0;
				end
			end
			PH_ENTRY: begin
				acc_d = acc_shift;
				pos_d = pos_inc;
				off_d = off_q + 1'b1;
				if (off_q >= OFF_ENTRY_LAST) begin
					have    = 1'b1;
					kind    = K_FLAGS;
					value   = {16'd0, flags};
					len_d   = flags[NLB-1:0];
					seen_d  = '0;
					phase_d = (len_d != '0) ? PH_NAME : PH_NUL;
					off_d   = '0;
				end else if (off_q[1:0] == 2'b11) begin
					have  = 1'b1;
					kind  = K_STAT_BASE + 5'(off_q[OFF_W-1:2]);
					value = acc_shift;
				end
			end
			PH_NAME: begin
				have   = 1'b1;
				kind   = K_NAME;
				value  = {24'd0, item_s1.data_byte};
				seen_d = seen_q + 1'b1;
				pos_d  = pos_inc;
				if (seen_d >= len_q) begin
					phase_d = PH_NUL;
				end
			end
			PH_NUL: begin
				if (item_s1.data_byte != 8'd0) begin
					err = ERR_NUL;
				end else if (pad_need == '0) begin
					finish = 1'b1;
				end else begin
					pad_d   = pad_need;
					phase_d = PH_PAD;
				end
			end
			PH_PAD: begin
				if (pad_q != '0) begin
					pad_d = pad_q - 1'b1;
				end
				if (pad_d == '0) begin
					finish = 1'b1;
				end
			end
			default: ;
		endcase

		// Close the entry once its padding is done.
		if (finish) begin
			have     = 1'b1;
			kind     = K_END;
			value    = 32'(len_q);
			number   = entry_q;
			entry_d  = entry_q + 1'b1;
			remain_d = remain_q - 1'b1;
			phase_d  = (remain_d != '0) ? PH_ENTRY : PH_TRAILER;
			off_d    = '0;
			pos_d    = '0;
		end

		// A file that ends before its trailer is truncated.
		if (err == ERR_NONE && item_s1.end_of_file &&
				phase_q != PH_TRAILER && phase_q != PH_HALT) begin
			err = ERR_TRUNCATED;
		end

		if (err != ERR_NONE) begin
			have    = 1'b1;
			kind    = K_ERROR;
			value   = '0;
			number  = entry_d;
			phase_d = PH_HALT;
		end else if (item_s1.end_of_file && phase_q == PH_TRAILER) begin
			// Clean end of file: start over for the next file.
			phase_d  = PH_HEADER;
			off_d    = '0;
			acc_d    = '0;
			remain_d = '0;
			entry_d  = '0;
			len_d    = '0;
			seen_d   = '0;
			pos_d    = '0;
			pad_d    = '0;
		end

		if (phase_q == PH_HALT) begin
			have = 1'b0;
		end

		res_valid        = have;
		res.record_kind  = kind;
		res.record_value = value;
		res.entry_number = number;
		res.error_code   = err;
	end

	// Parse state registers, updated once per consumed byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HEADER;
			off_q    <= '0;
			acc_q    <= '0;
			remain_q <= '0;
			entry_q  <= '0;
			len_q    <= '0;
			seen_q   <= '0;
			pos_q    <= '0;
			pad_q    <= '0;
		end else if (step) begin
			phase_q  <= phase_d;
			off_q    <= off_d;
			acc_q    <= acc_d;
			remain_q <= remain_d;
			entry_q  <= entry_d;
			len_q    <= len_d;
			seen_q   <= seen_d;
			pos_q    <= pos_d;
			pad_q    <= pad_d;
		end
	end

endmodule

`default_nettype wire

@@ rtl/gisp_out_reg.sv @@
// Result register stage of the index stream parser.
`timescale 1ns / 1ps
`default_nettype none

module gisp_out_reg (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              advance,
	input  wire logic              step,
	input  wire logic              res_valid,
	input  gisp_pkg::gisp_result_t res,
	output logic                   out_valid,
	output logic [4:0]             record_kind,
	output logic [31:0]            record_value,
	output logic [30:0]            entry_number,
	output logic [2:0]             error_code
);
	import gisp_pkg::*;

	logic load;

	assign load = step && res_valid;

	// The register is refilled whenever it is empty or its transaction completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			record_kind  <= res.record_kind;
			record_value <= res.record_value;
			entry_number <= res.entry_number;
			error_code   <= res.error_code;
		end
	end

endmodule

`default_nettype wire
